FILE: rtl/core/rau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_pkg
// Types and codes shared by the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_LT  = 3'd4;
    localparam logic [2:0] OP_EQ  = 3'd5;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DIV_ZERO = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    localparam logic [1:0] MUL_P0 = 2'd0;
    localparam logic [1:0] MUL_P1 = 2'd1;
    localparam logic [1:0] MUL_P2 = 2'd2;

    typedef struct packed {
        logic [2:0]         operation;
        logic signed [31:0] a_numerator;
        logic [30:0]        a_denominator;
        logic signed [31:0] b_numerator;
        logic [30:0]        b_denominator;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] result_numerator;
        logic [30:0]        result_denominator;
        logic               truth;
        logic [1:0]         status;
    } t_out_item;

    typedef struct packed {
        logic       load;
        logic       mul_en;
        logic [1:0] mul_idx;
        logic       combine;
        logic       gcd_step;
        logic       div_init;
        logic       div_step;
        logic       finish;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic early;
        logic gcd_done;
        logic div_last;
    } t_sts;

endpackage

FILE: rtl/core/rau_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_datapath
// Cross products, comparisons, binary gcd, exact division by the gcd and range check.
// ----------------------------------------------------------------------------
module rau_datapath #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic              i_clk,
    input  rau_pkg::t_in_item i_item,
    input  rau_pkg::t_cmd     i_cmd,
    output rau_pkg::t_sts     o_sts,
    output rau_pkg::t_out_item o_item
);
    import rau_pkg::*;

    localparam logic [63:0] LIM = 64'd1 << (VALUE_WIDTH - 1);

    t_in_item           r_op;
    logic signed [63:0] r_m0, r_m1, r_m2;
    logic [63:0]        r_u, r_v, r_g;
    logic [5:0]         r_k, r_cnt;
    logic [63:0]        r_qn, r_qd;
    logic [64:0]        r_rn, r_rd;
    logic               r_neg;
    t_out_item          r_res, r_out;

    logic signed [32:0] mul_x, mul_y;
    logic signed [65:0] mul_p;
    logic signed [63:0] c_num, c_den;
    logic               is_mul;
    logic               early;
    t_out_item          early_res, fin_res;
    logic [64:0]        sn, sd;
    logic               gen, ged;
    logic [63:0]        u_minus_v, v_minus_u;

    assign is_mul = (r_op.operation == OP_MUL);

    always_comb begin
        case (i_cmd.mul_idx)
            MUL_P0: begin
                mul_x = {r_op.a_numerator[31], r_op.a_numerator};
                mul_y = is_mul ? {r_op.b_numerator[31], r_op.b_numerator}
                               : {2'b00, r_op.b_denominator};
            end
            MUL_P1: begin
                mul_x = {2'b00, r_op.a_denominator};
                mul_y = is_mul ? {2'b00, r_op.b_denominator}
                               : {r_op.b_numerator[31], r_op.b_numerator};
            end
            default: begin
                mul_x = {2'b00, r_op.a_denominator};
                mul_y = {2'b00, r_op.b_denominator};
            end
        endcase
        mul_p = mul_x * mul_y;
    end

    always_comb begin
        case (r_op.operation)
            OP_ADD:  c_num = r_m0 + r_m1;
            OP_SUB:  c_num = r_m0 - r_m1;
            default: c_num = r_m0;
        endcase
        c_den = (r_op.operation == OP_DIV) ? r_m1 : r_m2;
    end

    always_comb begin
        early     = 1'b1;
        early_res = '{result_numerator: '0, result_denominator: 31'd1,
                      truth: 1'b0, status: ST_OK};
        if (r_op.operation > OP_EQ) begin
            early = 1'b1;
        end else if (r_op.a_denominator == '0 || r_op.b_denominator == '0) begin
            early_res.status = ST_DIV_ZERO;
        end else if (r_op.operation == OP_LT) begin
            early_res.truth = (r_m0 < r_m1);
        end else if (r_op.operation == OP_EQ) begin
            early_res.truth = (r_m0 == r_m1);
        end else if (r_op.operation == OP_DIV && r_op.b_numerator == '0) begin
            early_res.status = ST_DIV_ZERO;
        end else if (c_num == '0) begin
            early = 1'b1;
        end else begin
            early = 1'b0;
        end
    end

    assign u_minus_v = r_u - r_v;
    assign v_minus_u = r_v - r_u;
    assign sn  = {r_rn[63:0], r_qn[63]};
    assign sd  = {r_rd[63:0], r_qd[63]};
    assign gen = (sn >= {1'b0, r_g});
    assign ged = (sd >= {1'b0, r_g});

    always_comb begin
        fin_res = '{result_numerator: '0, result_denominator: 31'd1,
                    truth: 1'b0, status: ST_OK};
        if (r_qd > LIM - 64'd1 || (r_neg ? r_qn > LIM : r_qn > LIM - 64'd1)) begin
            fin_res.status = ST_OVERFLOW;
        end else begin
            fin_res.result_numerator   = r_neg ? -r_qn[31:0] : r_qn[31:0];
            fin_res.result_denominator = r_qd[30:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_item;
        end
        if (i_cmd.mul_en) begin
            case (i_cmd.mul_idx)
                MUL_P0:  r_m0 <= mul_p[63:0];
                MUL_P1:  r_m1 <= mul_p[63:0];
                default: r_m2 <= mul_p[63:0];
            endcase
        end
        if (i_cmd.combine) begin
            r_res <= early_res;
            r_neg <= c_num[63] ^ c_den[63];
            r_u   <= c_num[63] ? -c_num : c_num;
            r_v   <= c_den[63] ? -c_den : c_den;
            r_qn  <= c_num[63] ? -c_num : c_num;
            r_qd  <= c_den[63] ? -c_den : c_den;
            r_k   <= '0;
        end
        if (i_cmd.gcd_step) begin
            if (!r_u[0] && !r_v[0]) begin
                r_u <= r_u >> 1;
                r_v <= r_v >> 1;
                r_k <= r_k + 6'd1;
            end else if (!r_u[0]) begin
                r_u <= r_u >> 1;
            end else if (!r_v[0]) begin
                r_v <= r_v >> 1;
            end else if (r_u >= r_v) begin
                r_u <= u_minus_v >> 1;
            end else begin
                r_v <= v_minus_u >> 1;
            end
        end
        if (i_cmd.div_init) begin
            r_g   <= (r_u | r_v) << r_k;
            r_rn  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_rn  <= gen ? sn - {1'b0, r_g} : sn;
            r_rd  <= ged ? sd - {1'b0, r_g} : sd;
            r_qn  <= {r_qn[62:0], gen};
            r_qd  <= {r_qd[62:0], ged};
            r_cnt <= r_cnt + 6'd1;
        end
        if (i_cmd.finish) begin
            r_res <= fin_res;
        end
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

    assign o_sts.early    = early;
    assign o_sts.gcd_done = (r_u == '0) || (r_v == '0);
    assign o_sts.div_last = (r_cnt == 6'd63);
    assign o_item         = r_out;

endmodule

FILE: rtl/core/rau_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_ctrl
// Sequencer for the rational unit: issues datapath commands, drives handshakes.
// ----------------------------------------------------------------------------
module rau_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    output logic          o_valid,
    input  logic          i_stall,
    input  rau_pkg::t_sts i_sts,
    output rau_pkg::t_cmd o_cmd
);
    import rau_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_MUL0 = 10'b0000000010,
        S_MUL1 = 10'b0000000100,
        S_MUL2 = 10'b0000001000,
        S_COMB = 10'b0000010000,
        S_GCD  = 10'b0000100000,
        S_DIVI = 10'b0001000000,
        S_DIV  = 10'b0010000000,
        S_FIN  = 10'b0100000000,
        S_DONE = 10'b1000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_ovalid, n_ovalid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL0;
                end
            end
            S_MUL0: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_idx = MUL_P0;
                n_state       = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_idx = MUL_P1;
                n_state       = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_idx = MUL_P2;
                n_state       = S_COMB;
            end
            S_COMB: begin
                o_cmd.combine = 1'b1;
                n_state       = i_sts.early ? S_DONE : S_GCD;
            end
            S_GCD: begin
                if (i_sts.gcd_done) begin
                    n_state = S_DIVI;
                end else begin
                    o_cmd.gcd_step = 1'b1;
                end
            end
            S_DIVI: begin
                o_cmd.div_init = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (!r_ovalid || !i_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_ovalid = r_ovalid;
        if (o_cmd.out_load) begin
            n_ovalid = 1'b1;
        end else if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovalid;

endmodule

FILE: rtl/core/rational_arithmetic_unit.sv
`timescale 1ns / 1ps
// Sequence: comparisons, divide-by-zero cases and zero results finish after
//   the three cross products and the combine step; otherwise the binary gcd
//   loop and the 64-step exact division by the gcd follow, then the range check.
// Throughput: one item at a time; the next item is taken once the result
//   has moved to the output register. Synchronous active-low reset clears
//   the sequencer and the output valid.
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Exact add, subtract, multiply, divide and compare on reduced fractions.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  rau_pkg::t_in_item  i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output rau_pkg::t_out_item o_data
);
    import rau_pkg::*;

    t_cmd cmd;
    t_sts sts;

    rau_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    rau_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .i_clk  (i_clk),
        .i_item (i_data),
        .i_cmd  (cmd),
        .o_sts  (sts),
        .o_item (o_data)
    );

endmodule
